/* hw/rtl/sts_pkg.sv */
// Shared types and constants for the sorted table search and insert core.
package sts_pkg;

  // Fixed port widths
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned POS_W    = 6;

  // Default sizing
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_KEY_WIDTH   = 32;

  // Operation codes carried on kind
  typedef enum logic {
    OP_FIND   = 1'b0,
    OP_INSERT = 1'b1
  } op_kind_e;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SRCH  = 7'b0000010,
    ST_SCMP  = 7'b0000100,
    ST_FCMP  = 7'b0001000,
    ST_SHIFT = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_WR    = 7'b1000000
  } seq_state_e;

  // Outcome of the shared key comparator
  typedef struct packed {
    logic less;
    logic equal;
  } cmp_res_t;

  // Result word handed from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [POS_W-1:0] position;
    logic             full;
  } res_t;

endpackage

/* hw/rtl/sts_key_cmp.sv */
// Shared key comparator: ordered less-than under signed or unsigned mode, plus equality.
module sts_key_cmp #(
  parameter int unsigned KEY_WIDTH = sts_pkg::DEF_KEY_WIDTH
) (
  input  logic [KEY_WIDTH-1:0] a_i,
  input  logic [KEY_WIDTH-1:0] b_i,
  input  logic                 signed_i,
  output sts_pkg::cmp_res_t    res_o
);

  logic [KEY_WIDTH-1:0] sign_m;
  logic [KEY_WIDTH-1:0] a_x;
  logic [KEY_WIDTH-1:0] b_x;

  // Flip the sign bit so a signed order becomes an unsigned one
  assign sign_m = KEY_WIDTH'(signed_i) << (KEY_WIDTH - 1);
  assign a_x    = a_i ^ sign_m;
  assign b_x    = b_i ^ sign_m;

  assign res_o.less  = (a_x < b_x);
  assign res_o.equal = (a_i == b_i);

endmodule

/* hw/rtl/sts_seq.sv */
// Sequencer with key memory: binary search for the upper bound and insert shift.
module sts_seq #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = sts_pkg::DEF_KEY_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         kind_i,
  input  logic [sts_pkg::KEY_IN_W-1:0] key_i,
  output logic                         busy_o,
  output logic [KEY_WIDTH-1:0]         cmp_a_o,
  output logic [KEY_WIDTH-1:0]         cmp_b_o,
  input  sts_pkg::cmp_res_t            cmp_i,
  output sts_pkg::res_t                res_o
);

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW   = sts_pkg::KEY_IN_W + KEY_WIDTH;
  localparam int unsigned PXW  = CW + sts_pkg::POS_W;

  sts_pkg::seq_state_e state_q, state_d;
  sts_pkg::op_kind_e   kind_q, kind_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CW-1:0]        lo_q, lo_d;
  logic [CW-1:0]        hi_q, hi_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        src_q, src_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;

  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rdata_q;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [AW-1:0]        raddr;

  logic [CW-1:0]        mid;
  logic [CW-1:0]        lo_m1;
  logic [CW-1:0]        count_m1;
  logic [XW-1:0]        key_ext;
  logic [PXW-1:0]       pos_lo;
  logic [PXW-1:0]       pos_lo_m1;

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_m1     = lo_q - CW'(1);
  assign count_m1  = count_q - CW'(1);
  assign key_ext   = XW'(key_i);
  assign pos_lo    = PXW'(lo_q);
  assign pos_lo_m1 = PXW'(lo_m1);

  assign busy_o  = (state_q != sts_pkg::ST_IDLE);
  assign cmp_a_o = key_q;
  assign cmp_b_o = rdata_q;

  // Next state, memory port and result decode
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    key_d     = key_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    count_d   = count_q;
    src_d     = src_q;
    wr_pend_d = wr_pend_q;
    wr_addr_d = wr_addr_q;
    we        = 1'b0;
    waddr     = wr_addr_q;
    wdata     = rdata_q;
    raddr     = mid[AW-1:0];
    res_o     = '0;

    unique case (state_q)
      sts_pkg::ST_IDLE: begin
        if (start_i) begin
          kind_d  = sts_pkg::op_kind_e'(kind_i);
          key_d   = key_ext[KEY_WIDTH-1:0];
          lo_d    = '0;
          hi_d    = count_q;
          state_d = sts_pkg::ST_SRCH;
        end
      end

      sts_pkg::ST_SRCH: begin
        if (lo_q < hi_q) begin
          // probe the middle entry
          state_d = sts_pkg::ST_SCMP;
        end else if (kind_q == sts_pkg::OP_FIND) begin
          if (lo_q == '0) begin
            res_o.valid = 1'b1;
            state_d     = sts_pkg::ST_IDLE;
          end else begin
            raddr   = lo_m1[AW-1:0];
            state_d = sts_pkg::ST_FCMP;
          end
        end else if (count_q == CW'(TABLE_DEPTH)) begin
          // refuse insert into a full table
          res_o.valid = 1'b1;
          res_o.full  = 1'b1;
          state_d     = sts_pkg::ST_IDLE;
        end else if (count_q > lo_q) begin
          src_d     = count_m1[AW-1:0];
          wr_pend_d = 1'b0;
          state_d   = sts_pkg::ST_SHIFT;
        end else begin
          state_d = sts_pkg::ST_WR;
        end
      end

      sts_pkg::ST_SCMP: begin
        // narrow the search window
        if (cmp_i.less) begin
          hi_d = mid;
        end else begin
          lo_d = mid + CW'(1);
        end
        state_d = sts_pkg::ST_SRCH;
      end

      sts_pkg::ST_FCMP: begin
        res_o.valid = 1'b1;
        if (cmp_i.equal) begin
          res_o.hit      = 1'b1;
          res_o.position = pos_lo_m1[sts_pkg::POS_W-1:0];
        end
        state_d = sts_pkg::ST_IDLE;
      end

      sts_pkg::ST_SHIFT: begin
        // read one entry, write the entry read last cycle one slot up
        raddr     = src_q;
        we        = wr_pend_q;
        wr_pend_d = 1'b1;
        wr_addr_d = src_q + AW'(1);
        if (CW'(src_q) == lo_q) begin
          state_d = sts_pkg::ST_DRAIN;
        end else begin
          src_d = src_q - AW'(1);
        end
      end

      sts_pkg::ST_DRAIN: begin
        we        = 1'b1;
        wr_pend_d = 1'b0;
        state_d   = sts_pkg::ST_WR;
      end

      sts_pkg::ST_WR: begin
        // store the new key in the opened slot
        we             = 1'b1;
        waddr          = lo_q[AW-1:0];
        wdata          = key_q;
        count_d        = count_q + CW'(1);
        res_o.valid    = 1'b1;
        res_o.hit      = 1'b1;
        res_o.position = pos_lo[sts_pkg::POS_W-1:0];
        state_d        = sts_pkg::ST_IDLE;
      end

      default: begin
        state_d = sts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sts_pkg::ST_IDLE;
      count_q   <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    key_q     <= key_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    src_q     <= src_d;
    wr_addr_q <= wr_addr_d;
  end

  // Key memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule

/* hw/rtl/sorted_table_search_insert_core.sv */
// Sorted key table with find and insert; results are one-cycle strobes that cannot be
// stalled, so the receiver must take res_valid_o whenever it is high. A word is taken
// when start is high and busy is low; busy stays high until the result strobe. Find
// and insert run a binary search through the key memory, which has one write port and one
// registered read port, with up to log2(depth)+1 probes, each a read and a compare;
// after the last search step come the final compare or write and then the output
// register. An insert that lands below existing entries first moves each later entry
// up one slot, reading one entry while writing the one read before it; a full table
// is refused without moving anything. The result appears in the cycle after the
// sequencer finishes, and the next word may be accepted in that same cycle. The
// compare mode register is written through cfg_valid_i/cfg_ready_o while the core is
// idle and no word is being taken.
module sorted_table_search_insert_core #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = sts_pkg::DEF_KEY_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic [sts_pkg::KEY_IN_W-1:0] key_i,
  output logic                         res_valid_o,
  output logic                         hit_o,
  output logic [sts_pkg::POS_W-1:0]    position_o,
  output logic                         full_res_o
);

  logic                 signed_q;
  logic                 res_valid_q;
  logic                 hit_q;
  logic [sts_pkg::POS_W-1:0] position_q;
  logic                 full_q;

  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  sts_pkg::cmp_res_t    cmp_res;
  sts_pkg::res_t        seq_res;
  logic                 seq_busy;

  sts_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .key_i   (key_i),
    .busy_o  (seq_busy),
    .cmp_a_o (cmp_a),
    .cmp_b_o (cmp_b),
    .cmp_i   (cmp_res),
    .res_o   (seq_res)
  );

  sts_key_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .signed_i (signed_q),
    .res_o    (cmp_res)
  );

  assign busy        = seq_busy;
  assign cfg_ready_o = !seq_busy && !start;

  // Compare mode register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        signed_q <= cfg_data_i;
      end
      res_valid_q <= seq_res.valid;
    end
  end

  // Hold the result word for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (seq_res.valid) begin
      hit_q      <= seq_res.hit;
      position_q <= seq_res.position;
      full_q     <= seq_res.full;
    end
  end

  assign res_valid_o = res_valid_q;
  assign hit_o       = hit_q;
  assign position_o  = position_q;
  assign full_res_o  = full_q;

endmodule

/* hw/rtl/sts_checker.sv */
// Port-level checker for the sorted table core, bound to the top level.
module sts_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      res_valid_o,
  input logic                      hit_o,
  input logic [sts_pkg::POS_W-1:0] position_o,
  input logic                      full_res_o
);

  // A taken word always makes the core busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a word");

  // Result strobes never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for more than one cycle");

  // A refused insert never reports a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && full_res_o) |-> !hit_o)
    else $error("full flag together with hit");

  // A miss reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !hit_o) |-> (position_o == '0))
    else $error("nonzero position on a miss");

  // A result only closes out a word that kept the core busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a busy cycle before it");

endmodule

bind sorted_table_search_insert_core sts_checker u_sts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .hit_o       (hit_o),
  .position_o  (position_o),
  .full_res_o  (full_res_o)
);

/* tb/sts_result_checker.sv */
// Result checker for the sorted table core: mirrors the key table and compares every word.
module sts_result_checker
  import sts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                kind_i,
  input  logic [KEY_IN_W-1:0] key_i,
  input  logic                res_valid_i,
  input  logic                hit_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic                full_res_i,
  output int unsigned         outstanding_o,
  output int unsigned         fail_count_o
);

  localparam int unsigned DEPTH = DEF_TABLE_DEPTH;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
    logic             full;
  } lookup_word_t;

  // Mirror of the key table, its fill level and the compare mode
  logic [KEY_IN_W-1:0] mirror_keys [DEPTH];
  int unsigned         mirror_count = 0;
  logic                signed_order = 1'b0;
  lookup_word_t        awaited_words [$];

  // Strict less-than under the current compare mode
  function automatic logic key_below(input logic [KEY_IN_W-1:0] a, input logic [KEY_IN_W-1:0] b);
    if (signed_order) begin
      return $signed(a) < $signed(b);
    end
    return a < b;
  endfunction

  // Run the upper-bound search, update the mirror on insert, return the expected word
  function automatic lookup_word_t search_and_insert(input op_kind_e op,
                                                     input logic [KEY_IN_W-1:0] key);
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    int unsigned  i;
    lookup_word_t word;
    word = '0;
    lo   = 0;
    hi   = mirror_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_below(key, mirror_keys[mid])) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    if (op == OP_FIND) begin
      // last equal key sits just below the upper bound
      if (lo > 0 && mirror_keys[lo-1] == key) begin
        word.hit      = 1'b1;
        word.position = POS_W'(lo - 1);
      end
    end else if (mirror_count >= DEPTH) begin
      word.full = 1'b1;
    end else begin
      // open the slot at the upper bound
      for (i = mirror_count; i > lo; i--) begin
        mirror_keys[i] = mirror_keys[i-1];
      end
      mirror_keys[lo] = key;
      mirror_count++;
      word.hit      = 1'b1;
      word.position = POS_W'(lo);
    end
    return word;
  endfunction

  // Check leaving words, then track config writes and accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_word_t want;
    if (!rst_ni) begin
      mirror_count = 0;
      signed_order = 1'b0;
      fail_count_o = 0;
      awaited_words.delete();
      outstanding_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (awaited_words.size() == 0) begin
          $error("unexpected result word: hit %0d position %0d full_res %0d",
                 hit_i, position_i, full_res_i);
          fail_count_o++;
        end else begin
          want = awaited_words.pop_front();
          if (hit_i !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_i);
            fail_count_o++;
          end
          if (position_i !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position_i);
            fail_count_o++;
          end
          if (full_res_i !== want.full) begin
            $error("full_res: expected %0d, got %0d", want.full, full_res_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        awaited_words.push_back(search_and_insert(op_kind_e'(kind_i), key_i));
      end
      // a mode write takes effect for the next request
      if (cfg_valid_i && cfg_ready_i) begin
        signed_order = cfg_data_i;
      end
      outstanding_o <= awaited_words.size();
    end
  end

endmodule

/* tb/sorted_table_search_insert_core_test.sv */
// Top of the sorted table core test: clock, reset, request stimulus and the verdict.
module sorted_table_search_insert_core_test;
  import sts_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_data_i  = 1'b0;
  logic                start       = 1'b0;
  logic                kind_i      = 1'b0;
  logic [KEY_IN_W-1:0] key_i       = '0;
  logic                cfg_ready_o;
  logic                busy;
  logic                res_valid_o;
  logic                hit_o;
  logic [POS_W-1:0]    position_o;
  logic                full_res_o;
  int unsigned         outstanding;
  int unsigned         fail_count;
  int unsigned         stall_cycles = 0;
  logic [KEY_IN_W-1:0] stored_keys [$];

  sorted_table_search_insert_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .res_valid_o (res_valid_o),
    .hit_o       (hit_o),
    .position_o  (position_o),
    .full_res_o  (full_res_o)
  );

  sts_result_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start),
    .busy_i        (busy),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .res_valid_i   (res_valid_o),
    .hit_i         (hit_o),
    .position_i    (position_o),
    .full_res_i    (full_res_o),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: end the run once nothing has moved for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("sorted_table_search_insert_core: mismatch");
    $finish;
  end

  // Hand one request word to the core, with an optional gap placed at the busy release
  task automatic issue(input op_kind_e op, input logic [KEY_IN_W-1:0] key,
                       input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while (busy || $urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start  <= 1'b1;
    kind_i <= op;
    key_i  <= key;
    if (op == OP_INSERT) begin
      stored_keys.push_back(key);
    end
    do @(posedge clk_i); while (busy);
  endtask

  // Write the compare mode once every outstanding word has come back
  task automatic set_order(input logic signed_mode);
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= signed_mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Favor stored keys and their neighbors so searches land on hits and boundaries
  function automatic logic [KEY_IN_W-1:0] pick_key();
    int unsigned         roll;
    logic [KEY_IN_W-1:0] k;
    roll = $urandom_range(99);
    if (roll < 45 && stored_keys.size() != 0) begin
      k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      if (roll >= 30) begin
        k = ($urandom_range(1) != 0) ? k + 1'b1 : k - 1'b1;
      end
      return k;
    end
    if (roll < 60) begin
      case ($urandom_range(5))
        0: return '0;
        1: return 32'h0000_0001;
        2: return 32'h7fff_ffff;
        3: return 32'h8000_0000;
        4: return 32'hffff_fffe;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // Random requests with a given insert share and sender gap rate
  task automatic random_run(input int unsigned words, input int unsigned idle_pct,
                            input int unsigned insert_pct);
    repeat (words) begin
      issue(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_FIND, pick_key(), idle_pct);
    end
  endtask

  // Stimulus
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // unsigned order: empty table, extremes, duplicates after equal keys
    set_order(1'b0);
    issue(OP_FIND,   32'h0000_0000, 0);
    issue(OP_INSERT, 32'h8000_0000, 0);
    issue(OP_INSERT, 32'h0000_0000, 0);
    issue(OP_INSERT, 32'hffff_ffff, 0);
    issue(OP_INSERT, 32'h7fff_ffff, 0);
    issue(OP_INSERT, 32'h0000_0000, 0);
    issue(OP_INSERT, 32'h8000_0000, 0);
    issue(OP_FIND,   32'h0000_0000, 0);
    issue(OP_FIND,   32'hffff_ffff, 0);
    issue(OP_FIND,   32'h1234_5678, 0);
    issue(OP_FIND,   32'h8000_0000, 0);

    // signed order over a table sorted the other way
    set_order(1'b1);
    issue(OP_FIND,   32'h8000_0000, 0);
    issue(OP_FIND,   32'hffff_ffff, 0);
    issue(OP_FIND,   32'h7fff_ffff, 0);
    issue(OP_INSERT, 32'hffff_fffe, 0);
    issue(OP_INSERT, 32'h0000_0001, 0);
    issue(OP_FIND,   32'h0000_0001, 0);
    issue(OP_FIND,   32'h5555_5555, 0);
    issue(OP_FIND,   32'haaaa_aaaa, 0);

    // random phases; by the end of the last one the table is full and inserts hit the full refusal
    set_order(1'b0);
    random_run(240, 8, 12);
    set_order(1'b1);
    random_run(230, 47, 12);
    set_order(1'b0);
    random_run(230, 0, 30);

    // drain: wait for the last word, then give stray words time to show up
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sorted_table_search_insert_core: match");
    end else begin
      $display("sorted_table_search_insert_core: mismatch");
    end
    $finish;
  end

endmodule
